@@ rtl/aaf_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the accumulator ALU with flags.
// No dependencies; imported by aaf_alu and accumulator_alu_with_flags_top.
package aaf_pkg;

    typedef logic [4:0] t_action;

    // Operation codes
    localparam t_action ACT_ADD  = 5'd0;
    localparam t_action ACT_ADC  = 5'd1;
    localparam t_action ACT_SUB  = 5'd2;
    localparam t_action ACT_SBC  = 5'd3;
    localparam t_action ACT_AND  = 5'd4;
    localparam t_action ACT_XOR  = 5'd5;
    localparam t_action ACT_OR   = 5'd6;
    localparam t_action ACT_CP   = 5'd7;
    localparam t_action ACT_INC  = 5'd8;
    localparam t_action ACT_DEC  = 5'd9;
    localparam t_action ACT_RLCA = 5'd10;
    localparam t_action ACT_RRCA = 5'd11;
    localparam t_action ACT_RLA  = 5'd12;
    localparam t_action ACT_RRA  = 5'd13;
    localparam t_action ACT_CPL  = 5'd14;
    localparam t_action ACT_CCF  = 5'd15;
    localparam t_action ACT_SCF  = 5'd16;
    localparam t_action ACT_DAA  = 5'd17;

    // Flag bit positions
    localparam int unsigned FB_S  = 7;
    localparam int unsigned FB_Z  = 6;
    localparam int unsigned FB_F5 = 5;
    localparam int unsigned FB_H  = 4;
    localparam int unsigned FB_F3 = 3;
    localparam int unsigned FB_PV = 2;
    localparam int unsigned FB_N  = 1;
    localparam int unsigned FB_C  = 0;

    // Decimal adjust constants
    localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
    localparam logic [3:0] DAA_LO_LIMIT = 4'd9;
    localparam logic [3:0] DAA_LO_SUB   = 4'd6;
    localparam logic [7:0] DAA_LO_FIX   = 8'h06;
    localparam logic [7:0] DAA_HI_FIX   = 8'h60;

    typedef struct packed {
        t_action    action;
        logic [7:0] acc;
        logic [7:0] operand;
        logic [7:0] flags;
    } t_alu_in;

    typedef struct packed {
        logic [7:0] result;
        logic [7:0] flags;
        logic       write_back;
    } t_alu_out;

endpackage

@@ rtl/aaf_alu.sv @@
`timescale 1ns / 1ps
// Combinational core: result byte, flag byte and write-back mark for one operation.
// Depends on aaf_pkg.
module aaf_alu
    import aaf_pkg::*;
(
    input  t_alu_in  i_op,
    output t_alu_out o_res
);

    // S, Z, F5, F3 of a byte, other bits zero
    function automatic logic [7:0] szxy(input logic [7:0] v);
        logic [7:0] f;
        f        = v & 8'hA8;
        f[FB_Z]  = (v == 8'd0);
        return f;
    endfunction

    always_comb begin
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] f;
        logic       cin;
        logic       use_c;
        logic [8:0] add_s;
        logic [4:0] add_h;
        logic [8:0] sub_s;
        logic [4:0] sub_h;
        logic [7:0] add_f;
        logic [7:0] sub_f;
        logic [7:0] keep;
        logic [7:0] r;
        logic [7:0] nf;
        logic       wb;
        logic [7:0] diff;
        logic       dc;
        logic [7:0] logic_r;

        a     = i_op.acc;
        b     = i_op.operand;
        f     = i_op.flags;
        cin   = f[FB_C];
        use_c = cin & ((i_op.action == ACT_ADC) || (i_op.action == ACT_SBC));
        keep  = f & 8'hC4;

        add_s = {1'b0, a} + {1'b0, b} + {8'd0, use_c};
        add_h = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, use_c};
        sub_s = {1'b0, a} - {1'b0, b} - {8'd0, use_c};
        sub_h = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, use_c};

        add_f        = szxy(add_s[7:0]);
        add_f[FB_H]  = add_h[4];
        add_f[FB_PV] = ~(a[7] ^ b[7]) & (a[7] ^ add_s[7]);
        add_f[FB_C]  = add_s[8];

        sub_f        = szxy(sub_s[7:0]);
        sub_f[FB_N]  = 1'b1;
        sub_f[FB_H]  = sub_h[4];
        sub_f[FB_PV] = (a[7] ^ b[7]) & (a[7] ^ sub_s[7]);
        sub_f[FB_C]  = sub_s[8];

        r       = a;
        nf      = f;
        wb      = 1'b1;
        diff    = 8'd0;
        dc      = cin;
        logic_r = 8'd0;

        unique case (i_op.action)
            ACT_ADD, ACT_ADC: begin
                r  = add_s[7:0];
                nf = add_f;
            end
            ACT_SUB, ACT_SBC: begin
                r  = sub_s[7:0];
                nf = sub_f;
            end
            ACT_AND, ACT_XOR, ACT_OR: begin
                if (i_op.action == ACT_AND) begin
                    logic_r = a & b;
                end else if (i_op.action == ACT_XOR) begin
                    logic_r = a ^ b;
                end else begin
                    logic_r = a | b;
                end
                r         = logic_r;
                nf        = szxy(logic_r);
                nf[FB_PV] = ~^logic_r;
                nf[FB_H]  = (i_op.action == ACT_AND);
            end
            ACT_CP: begin
                nf         = sub_f;
                nf[FB_F5]  = b[FB_F5];
                nf[FB_F3]  = b[FB_F3];
                wb         = 1'b0;
            end
            ACT_INC: begin
                r         = b + 8'd1;
                nf        = szxy(r);
                nf[FB_C]  = cin;
                nf[FB_H]  = (b[3:0] == 4'hF);
                nf[FB_PV] = (b == 8'h7F);
            end
            ACT_DEC: begin
                r         = b - 8'd1;
                nf        = szxy(r);
                nf[FB_C]  = cin;
                nf[FB_N]  = 1'b1;
                nf[FB_H]  = (b[3:0] == 4'h0);
                nf[FB_PV] = (b == 8'h80);
            end
            ACT_RLCA, ACT_RRCA, ACT_RLA, ACT_RRA: begin
                if (i_op.action == ACT_RLCA) begin
                    r = {a[6:0], a[7]};
                end else if (i_op.action == ACT_RRCA) begin
                    r = {a[0], a[7:1]};
                end else if (i_op.action == ACT_RLA) begin
                    r = {a[6:0], cin};
                end else begin
                    r = {cin, a[7:1]};
                end
                nf        = keep | (r & 8'h28);
                nf[FB_C]  = ((i_op.action == ACT_RLCA) || (i_op.action == ACT_RLA))
                            ? a[7] : a[0];
            end
            ACT_CPL: begin
                r        = ~a;
                nf       = keep | (r & 8'h28);
                nf[FB_C] = cin;
                nf[FB_H] = 1'b1;
                nf[FB_N] = 1'b1;
            end
            ACT_CCF: begin
                nf       = keep | (a & 8'h28);
                nf[FB_H] = cin;
                nf[FB_C] = ~cin;
                wb       = 1'b0;
            end
            ACT_SCF: begin
                nf       = keep | (a & 8'h28);
                nf[FB_C] = 1'b1;
                wb       = 1'b0;
            end
            ACT_DAA: begin
                if (f[FB_H] || (a[3:0] > DAA_LO_LIMIT)) begin
                    diff = diff | DAA_LO_FIX;
                end
                if (cin || (a > DAA_HI_LIMIT)) begin
                    diff = diff | DAA_HI_FIX;
                    dc   = 1'b1;
                end
                r         = f[FB_N] ? (a - diff) : (a + diff);
                nf        = szxy(r);
                nf[FB_PV] = ~^r;
                nf[FB_N]  = f[FB_N];
                nf[FB_C]  = dc;
                nf[FB_H]  = f[FB_N] ? (f[FB_H] && (a[3:0] < DAA_LO_SUB))
                                    : (a[3:0] > DAA_LO_LIMIT);
            end
            default: begin
                // Undefined codes: no operation
                r  = a;
                nf = f;
                wb = 1'b0;
            end
        endcase

        o_res.result     = r;
        o_res.flags      = nf;
        o_res.write_back = wb;
    end

endmodule

@@ rtl/accumulator_alu_with_flags_top.sv @@
`timescale 1ns / 1ps
// Top level of the eight-bit accumulator ALU with flag generation.
// Depends on aaf_pkg and aaf_alu.
//
// One operation is taken on every clock: busy never rises, so start may stay
// high for any number of cycles and each cycle with start high is a transfer.
// The operation is captured in an input register at the transfer edge,
// evaluated by the combinational ALU core and captured in a result register
// at the next rising edge. Its result is on o_result, o_flags_out and
// o_write_back with o_strobe high for the one cycle that follows that edge,
// so it is taken at the rising edge that ends that cycle. The receiver
// cannot hold a result off and must take it in that cycle. Results leave in
// the order the operations arrived. There are two register stages, and the
// depth between them is one 9-bit add or subtract plus the flag selection.
// The block keeps no architectural state: the caller supplies the
// accumulator, operand and flag byte with each operation and writes back the
// result itself when o_write_back is high (cp, ccf, scf and undefined codes
// leave it low).
module accumulator_alu_with_flags_top
    import aaf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [4:0] i_action,
    input  logic [7:0] i_acc,
    input  logic [7:0] i_operand,
    input  logic [7:0] i_flags_in,
    output logic       o_strobe,
    output logic [7:0] o_result,
    output logic [7:0] o_flags_out,
    output logic       o_write_back
);

    logic     r_in_valid;
    t_alu_in  r_in;
    logic     r_out_valid;
    t_alu_out r_out;
    t_alu_out n_out;

    // Never stall the sender: both stages advance every cycle
    assign busy = 1'b0;

    // Input stage: valid cleared by reset, payload held without reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_in.action  <= i_action;
            r_in.acc     <= i_acc;
            r_in.operand <= i_operand;
            r_in.flags   <= i_flags_in;
        end
    end

    aaf_alu u_alu (
        .i_op  (r_in),
        .o_res (n_out)
    );

    // Result stage: strobe lasts one cycle per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_strobe     = r_out_valid;
    assign o_result     = r_out.result;
    assign o_flags_out  = r_out.flags;
    assign o_write_back = r_out.write_back;

endmodule
